// ----- rtl/max_tracking_stack_core_macros.svh -----
// Assertion macros used by the checker of the max tracking stack.
`ifndef MAX_TRACKING_STACK_CORE_MACROS_SVH
`define MAX_TRACKING_STACK_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define MTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define MTS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mts_pkg.sv -----
// Package with the types, sizes and codes of the max tracking stack.
package mts_pkg;

	// Sizes.
	localparam int unsigned STACK_DEPTH = 1024;
	localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned DEPTH_W     = 11;

	// Command codes; the unused code behaves as a query.
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// One command transaction.
	typedef struct packed {
		logic [1:0]               cmd;
		logic signed [DATA_W-1:0] value;
	} mts_req_t;

	// One result transaction.
	typedef struct packed {
		logic signed [DATA_W-1:0] data_out;
		logic signed [DATA_W-1:0] max_out;
		logic [DEPTH_W-1:0]       depth_out;
		logic [1:0]               status;
	} mts_rsp_t;

endpackage

// ----- rtl/mts_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module mts_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and read through a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/max_tracking_stack_core.sv -----
// Top level of the max tracking stack: control, cached top and maximum, two stack RAMs.
//
// Usage: a command transaction (req.cmd, req.value) is taken at a rising edge where
// start is high and busy is low. Push, query and the unused code keep busy low, and the
// next command may follow at once. A pop of a non-empty stack enters S_REFILL, and busy
// is high for one cycle while the entry below the old top, and the entry below the old
// maximum, come back from the value RAM and the maximum RAM, whose read ports are
// registered. A pop on an empty stack leaves busy low.
// Each result transaction is marked on rsp by done, which is high for a single cycle,
// in the cycle after the command (push, query, failed pop) or after the S_REFILL state
// (pop). The receiver cannot stall, so a result is never held back.
// The top value and the current maximum live in registers; the value RAM holds every
// entry, the maximum RAM each value pushed as a new maximum, and their read data is
// used only on a pop. Throughput is one command per cycle while busy is low.
// Reset empties the stack at once by clearing both counts; the RAM contents are
// left as they are and are never used before being written.
module max_tracking_stack_core
	import mts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  mts_req_t req,
	output logic     done,
	output mts_rsp_t rsp
);

	typedef enum logic {
		S_IDLE,
		S_REFILL
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         mcount_q;
	logic signed [DATA_W-1:0] top_q;
	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] pop_data_q;
	logic                     pop_max_q;
	logic                     done_q;
	mts_rsp_t                 rsp_q;

	logic                     accept;
	logic                     full;
	logic                     empty;
	logic                     qual;
	logic                     pop_max;
	logic signed [DATA_W-1:0] cur_max;
	logic [CNT_W-1:0]         rd_cnt;
	logic [CNT_W-1:0]         rd_mcnt;
	logic                     val_we;
	logic                     max_we;
	logic [DATA_W-1:0]        val_rdata;
	logic [DATA_W-1:0]        max_rdata;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Stack status seen by the command being accepted.
	assign full    = (count_q == CNT_W'(STACK_DEPTH));
	assign empty   = (count_q == '0);
	assign cur_max = (mcount_q == '0) ? '0 : max_q;
	assign qual    = (mcount_q == '0) || (req.value >= max_q);
	assign pop_max = (mcount_q != '0) && (top_q == max_q);

	// Writes happen on a successful push only.
	assign val_we = accept && (req.cmd == CMD_PUSH) && !full;
	assign max_we = val_we && qual;

	// The read port always looks at the entries below the cached top and maximum.
	assign rd_cnt  = count_q - CNT_W'(2);
	assign rd_mcnt = mcount_q - CNT_W'(2);

	mts_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (req.value),
		.raddr (rd_cnt[ADDR_W-1:0]),
		.rdata (val_rdata)
	);

	mts_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_max_ram (
		.clk   (clk),
		.we    (max_we),
		.waddr (mcount_q[ADDR_W-1:0]),
		.wdata (req.value),
		.raddr (rd_mcnt[ADDR_W-1:0]),
		.rdata (max_rdata)
	);

	// Control state: state, counts and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			mcount_q  <= '0;
			pop_max_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.cmd)
							CMD_PUSH: begin
								done_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
									if (qual) begin
										mcount_q <= mcount_q + CNT_W'(1);
									end
								end
							end
							CMD_POP: begin
								if (empty) begin
									done_q <= 1'b1;
								end else begin
									state_q   <= S_REFILL;
									pop_max_q <= pop_max;
									count_q   <= count_q - CNT_W'(1);
									if (pop_max) begin
										mcount_q <= mcount_q - CNT_W'(1);
									end
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_REFILL: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Cached top and maximum, and the result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.cmd)
						CMD_PUSH: begin
							if (full) begin
								rsp_q.data_out  <= '0;
								rsp_q.max_out   <= cur_max;
								rsp_q.depth_out <= DEPTH_W'(count_q);
								rsp_q.status    <= ST_FULL;
							end else begin
								top_q           <= req.value;
								rsp_q.data_out  <= req.value;
								rsp_q.depth_out <= DEPTH_W'(count_q + CNT_W'(1));
								rsp_q.status    <= ST_OK;
								if (qual) begin
									max_q         <= req.value;
									rsp_q.max_out <= req.value;
								end else begin
									rsp_q.max_out <= max_q;
								end
							end
						end
						CMD_POP: begin
							pop_data_q      <= top_q;
							rsp_q.data_out  <= '0;
							rsp_q.max_out   <= '0;
							rsp_q.depth_out <= '0;
							rsp_q.status    <= ST_EMPTY;
						end
						default: begin
							rsp_q.max_out   <= cur_max;
							rsp_q.depth_out <= DEPTH_W'(count_q);
							if (empty) begin
								rsp_q.data_out <= '0;
								rsp_q.status   <= ST_EMPTY;
							end else begin
								rsp_q.data_out <= top_q;
								rsp_q.status   <= ST_OK;
							end
						end
					endcase
				end
			end
			S_REFILL: begin
				// Counts already hold the values after the pop.
				rsp_q.data_out  <= pop_data_q;
				rsp_q.depth_out <= DEPTH_W'(count_q);
				rsp_q.status    <= ST_OK;
				if (count_q != '0) begin
					top_q <= val_rdata;
				end
				if (mcount_q == '0) begin
					rsp_q.max_out <= '0;
				end else if (pop_max_q) begin
					max_q         <= max_rdata;
					rsp_q.max_out <= max_rdata;
				end else begin
					rsp_q.max_out <= max_q;
				end
			end
			default: begin
				rsp_q <= rsp_q;
			end
		endcase
	end

endmodule

// ----- rtl/mts_chk.sv -----
// Port-level checker for the max tracking stack, with its bind statement.
`include "max_tracking_stack_core_macros.svh"

module mts_chk
	import mts_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input mts_req_t req,
	input logic     done,
	input mts_rsp_t rsp
);

	// An empty-stack error reports an empty stack and zero values.
	`MTS_ASSERT_IMP(a_empty_result, done && (rsp.status == ST_EMPTY), (rsp.depth_out == '0) && (rsp.data_out == '0) && (rsp.max_out == '0), "empty error with nonzero fields")

	// A full-stack error reports a full depth and no data.
	`MTS_ASSERT_IMP(a_full_result, done && (rsp.status == ST_FULL), (rsp.depth_out == DEPTH_W'(STACK_DEPTH)) && (rsp.data_out == '0), "full error with wrong fields")

	// A push transaction returns its result in the next cycle.
	`MTS_ASSERT_NXT(a_push_latency, start && !busy && (req.cmd == CMD_PUSH), done && !busy, "push result missing")

	// A result never reports an empty stack with a maximum.
	`MTS_ASSERT_IMP(a_empty_max, done && (rsp.depth_out == '0), rsp.max_out == '0, "maximum reported on empty stack")

endmodule

bind max_tracking_stack_core mts_chk u_mts_chk (.*);
